// ===== design/linear_probe_hash_map_defines.svh =====
// assertion macros for the linear probe hash map
// no dependencies; included by files that carry assertions
`ifndef LINEAR_PROBE_HASH_MAP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_DEFINES_SVH

// same-cycle implication
`define LPHM_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define LPHM_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== design/lphm_pkg.sv =====
// package for the linear probe hash map: sizes, hash constants, types
// no dependencies
package lphm_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int ADDR_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int LG_W      = 4;
  localparam int LG_MIN    = 3;
  localparam int LG_MAX    = ADDR_W;

  localparam logic [63:0] MIX_C0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2 = 64'h94D049BB133111EB;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_PRD,
    S_PCHK,
    S_SRD,
    S_SCHK,
    S_HOME,
    S_MOVE,
    S_VAC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        occ;
    logic [63:0] key;
    logic [31:0] val;
  } slot_t;

  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } mix_req_t;

endpackage

// ===== design/lphm_mix.sv =====
// iterative splitmix64 finalizer folded to 32 bits, one 32x32 product per cycle
// depends on lphm_pkg
module lphm_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  lphm_pkg::mix_req_t req,
  output logic              done,
  output logic [31:0]       hash
);
  import lphm_pkg::*;

  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        rnd_r, rnd_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [31:0] hash_r, hash_nxt;

  logic [63:0] mop, cst, sum, addend;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    mop = rnd_r ? (x_r ^ (x_r >> 27)) : (x_r ^ (x_r >> 30));
    cst = rnd_r ? MIX_C2 : MIX_C1;
    case (sub_r)
      2'd0: begin
        ma = mop[31:0];
        mb = cst[31:0];
      end
      2'd1: begin
        ma = mop[63:32];
        mb = cst[31:0];
      end
      default: begin
        ma = mop[31:0];
        mb = cst[63:32];
      end
    endcase
    prod   = 64'(ma) * 64'(mb);
    addend = (sub_r == 2'd0) ? prod : {prod[31:0], 32'd0};
    sum    = acc_r + addend;

    x_nxt    = x_r;
    acc_nxt  = acc_r;
    sub_nxt  = sub_r;
    rnd_nxt  = rnd_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    hash_nxt = hash_r;
    if (req.start) begin
      x_nxt   = req.key + MIX_C0;
      acc_nxt = '0;
      sub_nxt = 2'd0;
      rnd_nxt = 1'b0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (sub_r == 2'd2) begin
        x_nxt   = sum;
        acc_nxt = '0;
        sub_nxt = 2'd0;
        rnd_nxt = 1'b1;
        if (rnd_r) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          hash_nxt = sum[31:0] ^ sum[62:31];
        end
      end else begin
        acc_nxt = sum;
        sub_nxt = sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    sub_r  <= sub_nxt;
    rnd_r  <= rnd_nxt;
    hash_r <= hash_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

// ===== design/linear_probe_hash_map.sv =====
// linear probe hash map: 64-bit keys to 32-bit values, backward-shift removal
// depends on lphm_pkg, lphm_mix and linear_probe_hash_map_defines.svh
//
// input channel: in_valid/in_stall with in_opcode, in_lookup_key, in_new_value
// (0 get, 1 put, 2 remove, 3 clear). one transaction is worked at a time;
// in_stall is low only while the block is idle.
// result channel: out_valid/out_stall with out_success, out_found_value and
// out_entry_count; one result per input transaction, held in an output
// register until taken, so the next input is accepted while it waits.
// steps: hashing, then a read and a check for each slot probed, then loading
// the result. remove adds for each following entry a read and a rehash, and
// up to two writes (move into the hole, then vacate) for each displaced entry.
// clear sweeps all 1024 slots, one per cycle. the slot memory has one write
// port and one read port; one lphm_mix instance hashes lookup and displaced keys.
// reset: a clearing pass over all 1024 slots of the slot memory runs with in_stall
// high. a cfg_we write sets the table size and starts the same pass.
// a stalled result holds the block in its final state until taken.
module linear_probe_hash_map (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lphm_pkg::LG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [63:0]               in_lookup_key,
  input  logic [31:0]               in_new_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_success,
  output logic [31:0]               out_found_value,
  output logic [lphm_pkg::CNT_W-1:0] out_entry_count
);
  import lphm_pkg::*;
  `include "linear_probe_hash_map_defines.svh"

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [63:0]       key_r, key_nxt;
  logic [31:0]       val_r, val_nxt;
  logic [ADDR_W-1:0] s_r, s_nxt;
  logic [ADDR_W-1:0] hole_r, hole_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [ADDR_W-1:0] swp_r, swp_nxt;
  logic              clr_res_r, clr_res_nxt;
  logic              ok_r, ok_nxt;
  logic [31:0]       got_r, got_nxt;
  logic [63:0]       sk_r, sk_nxt;
  logic [31:0]       sv_r, sv_nxt;
  logic              ov_r, ov_nxt;
  logic              os_r, os_nxt;
  logic [31:0]       ofv_r, ofv_nxt;
  logic [CNT_W-1:0]  oec_r, oec_nxt;

  slot_t             mem [MAX_SLOTS];
  slot_t             rd_q;
  logic              we;
  logic [ADDR_W-1:0] wa;
  slot_t             wd;

  mix_req_t          mreq;
  logic              mdone;
  logic [31:0]       mhash;

  logic [LG_W-1:0]   lg_eff;
  logic [CNT_W-1:0]  cap;
  logic [ADDR_W-1:0] mask;
  logic [ADDR_W-1:0] home;
  logic              movable;
  logic              accept;
  logic [CNT_W-1:0]  n_inc;

  lphm_mix u_mix (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mdone),
    .hash (mhash)
  );

  always_comb begin
    if (lg_r < LG_W'(LG_MIN)) lg_eff = LG_W'(LG_MIN);
    else if (lg_r > LG_W'(LG_MAX)) lg_eff = LG_W'(LG_MAX);
    else lg_eff = lg_r;
    cap  = CNT_W'(1) << lg_eff;
    mask = ADDR_W'(cap - CNT_W'(1));
    home = mhash[ADDR_W-1:0] & mask;
    if (s_r > hole_r) movable = (home <= hole_r) || (home > s_r);
    else movable = (home <= hole_r) && (home > s_r);
  end

  assign in_stall = (state_r != S_IDLE) || cfg_we;
  assign accept   = in_valid && !in_stall;
  assign n_inc    = n_r + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    s_nxt       = s_r;
    hole_nxt    = hole_r;
    n_nxt       = n_r;
    cnt_nxt     = cnt_r;
    lg_nxt      = lg_r;
    swp_nxt     = swp_r;
    clr_res_nxt = clr_res_r;
    ok_nxt      = ok_r;
    got_nxt     = got_r;
    sk_nxt      = sk_r;
    sv_nxt      = sv_r;
    ov_nxt      = ov_r && out_stall;
    os_nxt      = os_r;
    ofv_nxt     = ofv_r;
    oec_nxt     = oec_r;
    we          = 1'b0;
    wa          = s_r;
    wd          = '0;
    mreq.start  = 1'b0;
    mreq.key    = in_lookup_key;

    case (state_r)
      S_SWEEP: begin
        we      = 1'b1;
        wa      = swp_r;
        swp_nxt = swp_r + ADDR_W'(1);
        if (swp_r == ADDR_W'(MAX_SLOTS - 1)) begin
          state_nxt = clr_res_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt  = op_t'(in_opcode);
          key_nxt = in_lookup_key;
          val_nxt = in_new_value;
          ok_nxt  = 1'b0;
          got_nxt = '0;
          n_nxt   = '0;
          if (op_t'(in_opcode) == OP_CLEAR) begin
            cnt_nxt     = '0;
            swp_nxt     = '0;
            clr_res_nxt = 1'b1;
            ok_nxt      = 1'b1;
            state_nxt   = S_SWEEP;
          end else begin
            mreq.start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mdone) begin
          s_nxt     = home;
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!rd_q.occ) begin
          if (op_r == OP_PUT) begin
            we      = 1'b1;
            wd      = '{occ: 1'b1, key: key_r, val: val_r};
            cnt_nxt = cnt_r + CNT_W'(1);
            ok_nxt  = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (rd_q.key == key_r) begin
          ok_nxt = 1'b1;
          case (op_r)
            OP_GET: begin
              got_nxt   = rd_q.val;
              state_nxt = S_DONE;
            end
            OP_PUT: begin
              we        = 1'b1;
              wd        = '{occ: 1'b1, key: key_r, val: val_r};
              state_nxt = S_DONE;
            end
            default: begin
              we        = 1'b1;
              if (cnt_r != '0) cnt_nxt = cnt_r - CNT_W'(1);
              hole_nxt  = s_r;
              s_nxt     = (s_r + ADDR_W'(1)) & mask;
              n_nxt     = '0;
              state_nxt = S_SRD;
            end
          endcase
        end else begin
          n_nxt = n_inc;
          if (n_inc == cap) begin
            state_nxt = S_DONE;
          end else begin
            s_nxt     = (s_r + ADDR_W'(1)) & mask;
            state_nxt = S_PRD;
          end
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        sk_nxt = rd_q.key;
        sv_nxt = rd_q.val;
        if (!rd_q.occ) begin
          state_nxt = S_DONE;
        end else begin
          mreq.start = 1'b1;
          mreq.key   = rd_q.key;
          state_nxt  = S_HOME;
        end
      end
      S_HOME: begin
        if (mdone) begin
          if (movable) begin
            state_nxt = S_MOVE;
          end else begin
            n_nxt = n_inc;
            if (n_inc == cap) begin
              state_nxt = S_DONE;
            end else begin
              s_nxt     = (s_r + ADDR_W'(1)) & mask;
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_MOVE: begin
        we        = 1'b1;
        wa        = hole_r;
        wd        = '{occ: 1'b1, key: sk_r, val: sv_r};
        state_nxt = S_VAC;
      end
      S_VAC: begin
        we       = 1'b1;
        hole_nxt = s_r;
        n_nxt    = n_inc;
        if (n_inc == cap) begin
          state_nxt = S_DONE;
        end else begin
          s_nxt     = (s_r + ADDR_W'(1)) & mask;
          state_nxt = S_SRD;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          os_nxt    = ok_r;
          ofv_nxt   = got_r;
          oec_nxt   = cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a size write restarts the clearing pass from any state
    if (cfg_we) begin
      lg_nxt      = cfg_wdata;
      cnt_nxt     = '0;
      swp_nxt     = '0;
      clr_res_nxt = 1'b0;
      state_nxt   = S_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[s_r];
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    s_r    <= s_nxt;
    hole_r <= hole_nxt;
    n_r    <= n_nxt;
    ok_r   <= ok_nxt;
    got_r  <= got_nxt;
    sk_r   <= sk_nxt;
    sv_r   <= sv_nxt;
    os_r   <= os_nxt;
    ofv_r  <= ofv_nxt;
    oec_r  <= oec_nxt;
    if (!rst_n) begin
      state_r   <= S_SWEEP;
      swp_r     <= '0;
      clr_res_r <= 1'b0;
      cnt_r     <= '0;
      lg_r      <= LG_W'(LG_MAX);
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      swp_r     <= swp_nxt;
      clr_res_r <= clr_res_nxt;
      cnt_r     <= cnt_nxt;
      lg_r      <= lg_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_success     = os_r;
  assign out_found_value = ofv_r;
  assign out_entry_count = oec_r;

  `LPHM_ASSERT_NOW(a_cnt_cap, clk, rst_n, 1'b1, cnt_r <= cap, "entry count above table size")
  `LPHM_ASSERT_NEXT(a_acc_busy, clk, rst_n, accept, state_r != S_IDLE, "accepted transaction lost")
  `LPHM_ASSERT_NOW(a_mix_wait, clk, rst_n, mdone, state_r == S_HASH || state_r == S_HOME,
                   "hash result with no waiter")

endmodule

// ===== test/linear_probe_hash_map_test.sv =====
// self-checking testbench for linear_probe_hash_map: an own hash-map predictor
// checks every result; depends on lphm_pkg and the linear_probe_hash_map rtl
`timescale 1ns / 100ps

module linear_probe_hash_map_test;
  import lphm_pkg::*;

  typedef struct {
    logic                  success;
    logic [31:0]           value;
    logic [CNT_W-1:0]      count;
  } map_result_t;

  class map_scoreboard;
    logic [63:0]      keys [MAX_SLOTS];
    logic [31:0]      vals [MAX_SLOTS];
    bit               occ  [MAX_SLOTS];
    int unsigned      count;
    logic [LG_W-1:0]  size_lg;
    map_result_t      pending [$];
    int               errors;

    function new();
      size_lg = 4'd10;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (occ[i]) occ[i] = 0;
      count = 0;
    endfunction

    function void set_size(logic [LG_W-1:0] lg);
      size_lg = lg;
      wipe();
    endfunction

    function int unsigned slots();
      if (size_lg < LG_MIN) return 1 << LG_MIN;
      if (size_lg > LG_MAX) return MAX_SLOTS;
      return 1 << size_lg;
    endfunction

    function logic [31:0] splitmix32(logic [63:0] k);
      logic [63:0] z;
      z = k + MIX_C0;
      z = (z ^ (z >> 30)) * MIX_C1;
      z = (z ^ (z >> 27)) * MIX_C2;
      z = z ^ (z >> 31);
      return z[31:0];
    endfunction

    function void note_input(op_t op, logic [63:0] key, logic [31:0] nv);
      int unsigned cap, mask, s, hole, p, home, n;
      bit hit, movable;
      map_result_t r;
      cap = slots();
      mask = cap - 1;
      r.success = 0;
      r.value = 0;
      case (op)
        OP_CLEAR: begin
          wipe();
          r.success = 1;
        end
        OP_GET: begin
          s = splitmix32(key) & mask;
          for (n = 0; n < cap && occ[s]; n++) begin
            if (keys[s] == key) begin
              r.success = 1;
              r.value = vals[s];
              break;
            end
            s = (s + 1) & mask;
          end
        end
        OP_PUT: begin
          s = splitmix32(key) & mask;
          for (n = 0; n < cap; n++) begin
            if (!occ[s]) begin
              occ[s] = 1;
              keys[s] = key;
              vals[s] = nv;
              count++;
              r.success = 1;
              break;
            end
            if (keys[s] == key) begin
              vals[s] = nv;
              r.success = 1;
              break;
            end
            s = (s + 1) & mask;
          end
        end
        default: begin
          hole = splitmix32(key) & mask;
          hit = 0;
          for (n = 0; n < cap && occ[hole]; n++) begin
            if (keys[hole] == key) begin
              hit = 1;
              break;
            end
            hole = (hole + 1) & mask;
          end
          if (hit) begin
            occ[hole] = 0;
            if (count > 0) count--;
            r.success = 1;
            p = hole;
            for (n = 0; n < cap; n++) begin
              p = (p + 1) & mask;
              if (!occ[p]) break;
              home = splitmix32(keys[p]) & mask;
              if (p > hole) movable = (home <= hole) || (home > p);
              else movable = (home <= hole) && (home > p);
              if (movable) begin
                keys[hole] = keys[p];
                vals[hole] = vals[p];
                occ[hole] = 1;
                occ[p] = 0;
                hole = p;
              end
            end
          end
        end
      endcase
      r.count = count[CNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic ok, logic [31:0] v, logic [CNT_W-1:0] c);
      map_result_t e;
      if (pending.size() == 0) begin
        $error("result transaction with no expected result");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ok !== e.success) begin
        $error("success: expected %0d, actual %0d", e.success, ok);
        errors++;
      end
      if (v !== e.value) begin
        $error("found_value: expected %h, actual %h", e.value, v);
        errors++;
      end
      if (c !== e.count) begin
        $error("entry_count: expected %0d, actual %0d", e.count, c);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [LG_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 0;
  logic              in_stall;
  logic [1:0]        in_opcode = '0;
  logic [63:0]       in_lookup_key = '0;
  logic [31:0]       in_new_value = '0;
  logic              out_valid;
  logic              out_stall = 0;
  logic              out_success;
  logic [31:0]       out_found_value;
  logic [CNT_W-1:0]  out_entry_count;

  map_scoreboard sb = new();
  logic [63:0] key_pool [$];
  int burst_left = 0;

  linear_probe_hash_map dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_lookup_key(in_lookup_key), .in_new_value(in_new_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_success(out_success), .out_found_value(out_found_value),
    .out_entry_count(out_entry_count)
  );

  always #10 clk = ~clk;

  // receiver stall pattern: free runs, random stalls, long stalls
  int stall_mode = 0;
  int mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(10, 200);
    end
    mode_left--;
    case (stall_mode)
      0: out_stall = 0;
      1: out_stall = ($urandom_range(0, 99) < 35);
      default: out_stall = ($urandom_range(0, 99) < 85);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_success, out_found_value, out_entry_count);
  end

  task automatic send(op_t op, logic [63:0] key, logic [31:0] nv);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_opcode = op;
    in_lookup_key = key;
    in_new_value = nv;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, key, nv);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_size(logic [LG_W-1:0] lg);
    drain();
    cfg_wdata = lg;
    cfg_we = 1;
    @(negedge clk);
    cfg_we = 0;
    sb.set_size(lg);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(logic [LG_W-1:0] lg, int items);
    int unsigned pool_n, pick;
    logic [63:0] k;
    op_t op;
    write_size(lg);
    pool_n = sb.slots() + sb.slots() / 2;
    if (pool_n > 48) pool_n = 48;
    key_pool.delete();
    repeat (pool_n) key_pool.push_back(rand_key());
    for (int i = 0; i < items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = OP_PUT;
      else if (pick < 75) op = OP_GET;
      else if (pick < 97) op = OP_REMOVE;
      else op = OP_CLEAR;
      k = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_n - 1)]
                                       : rand_key();
      send(op, k, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1;

    // directed: default size
    send(OP_GET, 64'h0, 32'h0);
    send(OP_PUT, 64'h0, 32'h0);
    send(OP_PUT, '1, '1);
    send(OP_GET, 64'h0, '1);
    send(OP_GET, '1, 32'h0);
    send(OP_PUT, '1, 32'h5A5A_A5A5);
    send(OP_GET, '1, 32'h0);
    send(OP_REMOVE, 64'h0, 32'h0);
    send(OP_REMOVE, 64'h0, 32'h0);
    send(OP_GET, 64'h0, 32'h0);
    send(OP_CLEAR, '1, '1);
    send(OP_GET, '1, 32'h0);

    // directed: smallest table filled past capacity
    write_size(4'd3);
    for (int i = 0; i < 9; i++) send(OP_PUT, 64'h100 + i, 32'h1000 + i);
    send(OP_GET, 64'hDEAD_BEEF_0000_0001, 32'h0);
    send(OP_PUT, 64'h103, 32'hFFFF_0000);
    send(OP_GET, 64'h103, 32'h0);
    send(OP_REMOVE, 64'h101, 32'h0);
    send(OP_REMOVE, 64'h105, 32'h0);
    send(OP_GET, 64'h106, 32'h0);
    send(OP_REMOVE, 64'hDEAD_BEEF_0000_0001, 32'h0);

    random_phase(4'd3, 140);
    random_phase(4'd4, 140);
    random_phase(4'd0, 130);
    random_phase(4'd5, 130);
    random_phase(4'd15, 120);
    random_phase(4'd6, 130);
    random_phase(4'd12, 110);
    random_phase(4'd3, 150);
    random_phase(4'd10, 120);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(20 * 4_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
